FILE: rtl/rca_pkg.sv
// rca_pkg: widths, codes and the descriptor type shared by the route checker
// front end, its queue and its back end
// no dependencies
package rca_pkg;

	localparam int MAX_PORTS   = 64;
	localparam int MIN_PORTS   = 2;
	localparam int PORT_W      = 6;
	localparam int CNT_W       = 7;
	localparam int DIST_W      = 16;
	localparam int TOTAL_W     = 22;
	localparam int ADDR_W      = 2 * PORT_W;
	localparam int DIST_DEPTH  = MAX_PORTS * MAX_PORTS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int OUT_DEPTH   = 2;

	localparam logic [TOTAL_W-1:0] DIST_SAT = '1;

	localparam logic [1:0] MODE_DIST  = 2'd0;
	localparam logic [1:0] MODE_PORT  = 2'd1;
	localparam logic [1:0] MODE_ROUTE = 2'd2;

	typedef enum logic [1:0] {
		OP_DIST  = 2'd0,
		OP_PORT  = 2'd1,
		OP_ROUTE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_ORIGIN = 3'd1,
		ERR_INDEX  = 3'd2,
		ERR_DRAFT  = 3'd3,
		ERR_DEMAND = 3'd4,
		ERR_RETURN = 3'd5
	} err_t;

	typedef struct packed {
		op_t                 op;
		logic [ADDR_W-1:0]   dist_addr;
		logic [PORT_W-1:0]   port;
		logic [DIST_W-1:0]   data;
		logic                demand;
		err_t                pre_err;
		logic [PORT_W-1:0]   load;
		logic                last;
	} desc_t;

	typedef struct packed {
		logic                valid;
		err_t                code;
		logic [TOTAL_W-1:0]  total;
	} result_t;

endpackage

FILE: rtl/route_check_and_length.sv
// Route checker: one input word per cycle, loads and route ports alike.
// A route result passes the descriptor queue, check stage and result buffer before the outputs.
// Throughput: 1 word per cycle, set by the one-port distance memory read per route port.
// Input stalls only when the 4-deep descriptor queue fills behind a full 2-entry result buffer.
// Reset: route state, queues and num_ports (64) clear at once; tables are undefined until loaded.
module route_check_and_length (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rca_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    mode,
	input  logic [rca_pkg::PORT_W-1:0]    row_port,
	input  logic [rca_pkg::PORT_W-1:0]    col_port,
	input  logic [rca_pkg::DIST_W-1:0]    leg_distance,
	input  logic [rca_pkg::DIST_W-1:0]    draft_limit,
	input  logic                          has_demand,
	input  logic [rca_pkg::PORT_W-1:0]    route_port,
	output logic                          empty,
	input  logic                          pop,
	output logic                          route_valid,
	output logic [2:0]                    error_code,
	output logic [rca_pkg::TOTAL_W-1:0]   total_distance
);

	logic [rca_pkg::CNT_W-1:0] num_ports_q;
	logic [rca_pkg::CNT_W-1:0] n_eff;
	logic                      q_full;
	logic                      q_push;
	logic                      q_pop;
	logic                      q_empty;
	rca_pkg::desc_t            q_desc;
	rca_pkg::desc_t            q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ports_q <= rca_pkg::CNT_W'(rca_pkg::MAX_PORTS);
		end else if (cfg_we) begin
			num_ports_q <= cfg_wdata;
		end
	end

	// out-of-range port counts are clamped
	always_comb begin
		if (num_ports_q < rca_pkg::CNT_W'(rca_pkg::MIN_PORTS)) begin
			n_eff = rca_pkg::CNT_W'(rca_pkg::MIN_PORTS);
		end else if (num_ports_q > rca_pkg::CNT_W'(rca_pkg::MAX_PORTS)) begin
			n_eff = rca_pkg::CNT_W'(rca_pkg::MAX_PORTS);
		end else begin
			n_eff = num_ports_q;
		end
	end

	rca_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_clear    (cfg_we),
		.n            (n_eff),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.row_port     (row_port),
		.col_port     (col_port),
		.leg_distance (leg_distance),
		.draft_limit  (draft_limit),
		.has_demand   (has_demand),
		.route_port   (route_port),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_desc       (q_desc)
	);

	rca_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_desc (q_desc),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	rca_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_clear      (cfg_we),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.route_valid    (route_valid),
		.error_code     (error_code),
		.total_distance (total_distance)
	);

endmodule

FILE: rtl/rca_front.sv
// rca_front: accepts input words, tracks route position and previous port,
// and turns each load or route word into a descriptor for the back end
// depends on rca_pkg
module rca_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_clear,
	input  logic [rca_pkg::CNT_W-1:0]    n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   mode,
	input  logic [rca_pkg::PORT_W-1:0]   row_port,
	input  logic [rca_pkg::PORT_W-1:0]   col_port,
	input  logic [rca_pkg::DIST_W-1:0]   leg_distance,
	input  logic [rca_pkg::DIST_W-1:0]   draft_limit,
	input  logic                         has_demand,
	input  logic [rca_pkg::PORT_W-1:0]   route_port,
	input  logic                         q_full,
	output logic                         q_push,
	output rca_pkg::desc_t               q_desc
);

	logic [rca_pkg::CNT_W-1:0]  pos_q;
	logic [rca_pkg::PORT_W-1:0] prev_q;
	logic                       accept;
	logic                       last;
	logic [rca_pkg::CNT_W-1:0]  load_full;
	logic [rca_pkg::CNT_W-1:0]  port_ext;

	assign full      = q_full;
	assign accept    = push && !q_full;
	assign last      = (pos_q + rca_pkg::CNT_W'(1)) >= n;
	assign load_full = n - rca_pkg::CNT_W'(1) - pos_q;
	assign port_ext  = {1'b0, route_port};

	always_comb begin
		q_desc = '0;
		q_push = 1'b0;
		case (mode)
			rca_pkg::MODE_DIST: begin
				q_desc.op        = rca_pkg::OP_DIST;
				q_desc.dist_addr = {row_port, col_port};
				q_desc.data      = leg_distance;
				q_push           = accept;
			end
			rca_pkg::MODE_PORT: begin
				q_desc.op     = rca_pkg::OP_PORT;
				q_desc.port   = row_port;
				q_desc.data   = draft_limit;
				q_desc.demand = has_demand;
				q_push        = accept;
			end
			rca_pkg::MODE_ROUTE: begin
				q_desc.op        = rca_pkg::OP_ROUTE;
				q_desc.dist_addr = {prev_q, route_port};
				q_desc.port      = route_port;
				q_desc.load      = load_full[rca_pkg::PORT_W-1:0];
				q_desc.last      = last;
				q_push           = accept;
				// draft and demand checks need table data, done in the back end
				if (last) begin
					q_desc.pre_err = (route_port != '0) ? rca_pkg::ERR_RETURN
						: rca_pkg::ERR_NONE;
				end else if (port_ext >= n) begin
					q_desc.pre_err = rca_pkg::ERR_INDEX;
				end else if (route_port == '0) begin
					q_desc.pre_err = rca_pkg::ERR_ORIGIN;
				end else begin
					q_desc.pre_err = rca_pkg::ERR_NONE;
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
		end else if (cfg_clear) begin
			pos_q  <= '0;
			prev_q <= '0;
		end else if (accept && mode == rca_pkg::MODE_ROUTE) begin
			// the next route starts again from the origin
			prev_q <= last ? '0 : route_port;
			pos_q  <= last ? '0 : pos_q + rca_pkg::CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < n)
		else $error("route position beyond port count");
	a_route_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == rca_pkg::MODE_ROUTE && last && !cfg_clear |=> pos_q == '0)
		else $error("route position not cleared after last port");
	a_push_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> accept)
		else $error("queue push without accepted word");
`endif

endmodule

FILE: rtl/rca_queue.sv
// rca_queue: short descriptor queue between front and back end
// depends on rca_pkg
module rca_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rca_pkg::desc_t  wr_desc,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output rca_pkg::desc_t  head
);

	rca_pkg::desc_t                mem_q [rca_pkg::QUEUE_DEPTH];
	logic [rca_pkg::QPTR_W-1:0]    wr_q;
	logic [rca_pkg::QPTR_W-1:0]    rd_q;
	logic [rca_pkg::QPTR_W:0]      cnt_q;

	assign full  = cnt_q == (rca_pkg::QPTR_W+1)'(rca_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + rca_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + rca_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (rca_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (rca_pkg::QPTR_W+1)'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty descriptor queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full descriptor queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (rca_pkg::QPTR_W+1)'(rca_pkg::QUEUE_DEPTH))
		else $error("descriptor queue count overflow");
`endif

endmodule

FILE: rtl/rca_back.sv
// rca_back: table memories, route checks, length accumulation and result buffer
// depends on rca_pkg
module rca_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_clear,
	input  logic                          q_empty,
	input  rca_pkg::desc_t                q_head,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic                          route_valid,
	output logic [2:0]                    error_code,
	output logic [rca_pkg::TOTAL_W-1:0]   total_distance
);

	logic [rca_pkg::DIST_W-1:0]  dist_mem   [rca_pkg::DIST_DEPTH];
	logic [rca_pkg::DIST_W-1:0]  draft_mem  [rca_pkg::MAX_PORTS];
	logic                        demand_mem [rca_pkg::MAX_PORTS];

	logic                        v_s2;
	rca_pkg::desc_t              desc_s2;
	logic [rca_pkg::DIST_W-1:0]  dist_rd_s2;
	logic [rca_pkg::DIST_W-1:0]  draft_rd_s2;
	logic                        demand_rd_s2;

	logic [rca_pkg::TOTAL_W-1:0]   run_q;
	rca_pkg::err_t                 first_q;
	logic [rca_pkg::MAX_PORTS-1:0] served_q;

	rca_pkg::result_t            out_mem_q [rca_pkg::OUT_DEPTH];
	logic                        out_wr_q;
	logic                        out_rd_q;
	logic [1:0]                  out_cnt_q;

	logic                        adv;
	logic                        route_s2;
	logic                        emit;
	logic                        fire_s2;
	logic                        out_full;
	logic                        out_pop;
	logic                        served_hit;
	logic                        mark;
	rca_pkg::err_t               err;
	rca_pkg::err_t               new_first;
	logic [rca_pkg::TOTAL_W:0]   sum;
	logic [rca_pkg::TOTAL_W-1:0] sum_sat;
	rca_pkg::result_t            res;

	assign out_full = out_cnt_q == 2'(rca_pkg::OUT_DEPTH);
	assign empty    = out_cnt_q == '0;
	assign out_pop  = pop && !empty;

	assign route_s2 = v_s2 && desc_s2.op == rca_pkg::OP_ROUTE;
	assign emit     = route_s2 && desc_s2.last;
	assign fire_s2  = v_s2 && !(emit && out_full);
	assign adv      = !v_s2 || fire_s2;
	assign q_pop    = adv && !q_empty;

	// one memory operation per word, so a load is seen by the next route word
	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == rca_pkg::OP_DIST) begin
			dist_mem[q_head.dist_addr] <= q_head.data;
		end
		if (q_pop && q_head.op == rca_pkg::OP_ROUTE) begin
			dist_rd_s2 <= dist_mem[q_head.dist_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == rca_pkg::OP_PORT) begin
			draft_mem[q_head.port]  <= q_head.data;
			demand_mem[q_head.port] <= q_head.demand;
		end
		if (q_pop && q_head.op == rca_pkg::OP_ROUTE) begin
			draft_rd_s2  <= draft_mem[q_head.port];
			demand_rd_s2 <= demand_mem[q_head.port];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			desc_s2 <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= q_pop;
		end
	end

	// draft and demand checks, first error, length with saturation
	always_comb begin
		served_hit = served_q[desc_s2.port];
		mark       = 1'b0;
		if (desc_s2.pre_err != rca_pkg::ERR_NONE || desc_s2.last) begin
			err = desc_s2.pre_err;
		end else if (draft_rd_s2 <
				{{(rca_pkg::DIST_W-rca_pkg::PORT_W){1'b0}}, desc_s2.load}) begin
			err = rca_pkg::ERR_DRAFT;
		end else if (!demand_rd_s2 || served_hit) begin
			err = rca_pkg::ERR_DEMAND;
		end else begin
			err  = rca_pkg::ERR_NONE;
			mark = 1'b1;
		end
		new_first = (first_q != rca_pkg::ERR_NONE) ? first_q : err;
		sum = {1'b0, run_q}
			+ {{(rca_pkg::TOTAL_W+1-rca_pkg::DIST_W){1'b0}}, dist_rd_s2};
		sum_sat = sum[rca_pkg::TOTAL_W] ? rca_pkg::DIST_SAT
			: sum[rca_pkg::TOTAL_W-1:0];
		res.valid = new_first == rca_pkg::ERR_NONE;
		res.code  = new_first;
		res.total = sum_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			first_q  <= rca_pkg::ERR_NONE;
			served_q <= '0;
		end else if (cfg_clear) begin
			run_q    <= '0;
			first_q  <= rca_pkg::ERR_NONE;
			served_q <= '0;
		end else if (fire_s2 && route_s2) begin
			if (desc_s2.last) begin
				run_q    <= '0;
				first_q  <= rca_pkg::ERR_NONE;
				served_q <= '0;
			end else begin
				run_q   <= sum_sat;
				first_q <= new_first;
				if (mark) begin
					served_q[desc_s2.port] <= 1'b1;
				end
			end
		end
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (fire_s2 && emit) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			if (fire_s2 && emit) begin
				out_wr_q <= !out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= !out_rd_q;
			end
			if ((fire_s2 && emit) && !out_pop) begin
				out_cnt_q <= out_cnt_q + 2'd1;
			end else if (out_pop && !(fire_s2 && emit)) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	assign route_valid    = out_mem_q[out_rd_q].valid;
	assign error_code     = out_mem_q[out_rd_q].code;
	assign total_distance = out_mem_q[out_rd_q].total;

`ifndef SYNTHESIS
	a_served_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 && emit |=> served_q == '0)
		else $error("served marks not cleared after route end");
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= 2'(rca_pkg::OUT_DEPTH))
		else $error("result buffer overflow");
	a_pop_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> v_s2)
		else $error("popped word lost before check stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !fire_s2 |=> v_s2 && $stable(desc_s2))
		else $error("stalled check stage changed");
`endif

endmodule

FILE: verif/route_verdict_checker.sv
`timescale 1ns / 1ps
// route_verdict_checker: watches the config, input and result queues of route_check_and_length,
// predicts each route verdict and compares it field by field
// depends on rca_pkg
module route_verdict_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rca_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                          push,
	input  logic                          full,
	input  logic [1:0]                    mode,
	input  logic [rca_pkg::PORT_W-1:0]    row_port,
	input  logic [rca_pkg::PORT_W-1:0]    col_port,
	input  logic [rca_pkg::DIST_W-1:0]    leg_distance,
	input  logic [rca_pkg::DIST_W-1:0]    draft_limit,
	input  logic                          has_demand,
	input  logic [rca_pkg::PORT_W-1:0]    route_port,
	input  logic                          empty,
	input  logic                          pop,
	input  logic                          route_valid,
	input  logic [2:0]                    error_code,
	input  logic [rca_pkg::TOTAL_W-1:0]   total_distance,
	output int                            mismatches,
	output int                            pending_verdicts
);
	import rca_pkg::*;

	localparam int REPORT_CAP = 60;

	logic [DIST_W-1:0]  leg_tab [DIST_DEPTH];
	logic [DIST_W-1:0]  draft_tab [MAX_PORTS];
	logic               demand_tab [MAX_PORTS];
	logic               served [MAX_PORTS];
	int                 port_cnt = MAX_PORTS;
	int                 route_pos = 0;
	logic [PORT_W-1:0]  last_port = '0;
	logic [TOTAL_W-1:0] route_len = '0;
	err_t               first_fault = ERR_NONE;
	result_t            verdicts_due [$];
	int                 fail_count = 0;
	int                 verdicts_waiting = 0;

	assign mismatches = fail_count;
	assign pending_verdicts = verdicts_waiting;

	task automatic restart_route();
		foreach (served[i]) served[i] = 1'b0;
		route_pos = 0;
		last_port = '0;
		route_len = '0;
		first_fault = ERR_NONE;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		if (fail_count < REPORT_CAP)
			$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	// one accepted input word: table loads, or one step along the route
	task automatic take_word();
		err_t               fault;
		logic [TOTAL_W:0]   sum;
		int                 load;
		result_t            v;
		fault = ERR_NONE;
		case (mode)
			MODE_DIST: leg_tab[{row_port, col_port}] = leg_distance;
			MODE_PORT: begin
				draft_tab[row_port] = draft_limit;
				demand_tab[row_port] = has_demand;
			end
			MODE_ROUTE: begin
				if (route_pos + 1 < port_cnt) begin
					load = port_cnt - 1 - route_pos;
					if (route_port >= port_cnt)
						fault = ERR_INDEX;
					else if (route_port == 0)
						fault = ERR_ORIGIN;
					else if (draft_tab[route_port] < load)
						fault = ERR_DRAFT;
					else if (!demand_tab[route_port] || served[route_port])
						fault = ERR_DEMAND;
					else
						served[route_port] = 1'b1;
				end else if (route_port != 0) begin
					fault = ERR_RETURN;
				end
				if (first_fault == ERR_NONE)
					first_fault = fault;
				sum = route_len + leg_tab[{last_port, route_port}];
				route_len = (sum > DIST_SAT) ? DIST_SAT : sum[TOTAL_W-1:0];
				last_port = route_port;
				route_pos++;
				if (route_pos >= port_cnt) begin
					v.valid = (first_fault == ERR_NONE);
					v.code = first_fault;
					v.total = route_len;
					verdicts_due.push_back(v);
					restart_route();
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			port_cnt = MAX_PORTS;
			restart_route();
			verdicts_due.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_wdata < MIN_PORTS)
					port_cnt = MIN_PORTS;
				else if (cfg_wdata > MAX_PORTS)
					port_cnt = MAX_PORTS;
				else
					port_cnt = cfg_wdata;
				restart_route();
			end
			if (push && !full)
				take_word();
			if (pop && !empty) begin
				if (verdicts_due.size() == 0) begin
					flag_mismatch("result word with none expected, total_distance",
						total_distance, 0);
				end else begin
					want = verdicts_due.pop_front();
					if (route_valid !== want.valid)
						flag_mismatch("route_valid", route_valid, want.valid);
					if (error_code !== want.code)
						flag_mismatch("error_code", error_code, want.code);
					if (total_distance !== want.total)
						flag_mismatch("total_distance", total_distance, want.total);
				end
			end
		end
		verdicts_waiting = verdicts_due.size();
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// tb: drives loads and routes into route_check_and_length and gives the verdict
// depends on rca_pkg, route_check_and_length and route_verdict_checker for prediction and comparison
module tb;
	import rca_pkg::*;

	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	localparam int         ITEM_TARGET  = 900;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         STALL_LIMIT  = 4000;

	typedef enum int {
		FLAW_NONE,
		FLAW_ORIGIN,
		FLAW_INDEX,
		FLAW_DRAFT,
		FLAW_DEMAND,
		FLAW_REPEAT,
		FLAW_RETURN
	} route_flaw_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CNT_W-1:0]    cfg_wdata;
	logic                push;
	logic                full;
	logic [1:0]          mode;
	logic [PORT_W-1:0]   row_port;
	logic [PORT_W-1:0]   col_port;
	logic [DIST_W-1:0]   leg_distance;
	logic [DIST_W-1:0]   draft_limit;
	logic                has_demand;
	logic [PORT_W-1:0]   route_port;
	logic                empty;
	logic                pop = 1'b0;
	logic                route_valid;
	logic [2:0]          error_code;
	logic [TOTAL_W-1:0]  total_distance;

	int mismatches;
	int pending_verdicts;
	int send_idle_pct = 38;
	int pop_idle_pct = 48;
	int stray_pct = 0;
	int words_sent = 0;
	int stall_cycles = 0;

	// where the route stands, so that every table entry is loaded before it is read
	int                gen_ports = MAX_PORTS;
	int                gen_pos = 0;
	logic [PORT_W-1:0] gen_prev = '0;
	bit                leg_loaded [DIST_DEPTH];
	bit                port_loaded [MAX_PORTS];

	route_check_and_length dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.push           (push),
		.full           (full),
		.mode           (mode),
		.row_port       (row_port),
		.col_port       (col_port),
		.leg_distance   (leg_distance),
		.draft_limit    (draft_limit),
		.has_demand     (has_demand),
		.route_port     (route_port),
		.empty          (empty),
		.pop            (pop),
		.route_valid    (route_valid),
		.error_code     (error_code),
		.total_distance (total_distance)
	);

	route_verdict_checker verdict_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.push             (push),
		.full             (full),
		.mode             (mode),
		.row_port         (row_port),
		.col_port         (col_port),
		.leg_distance     (leg_distance),
		.draft_limit      (draft_limit),
		.has_demand       (has_demand),
		.route_port       (route_port),
		.empty            (empty),
		.pop              (pop),
		.route_valid      (route_valid),
		.error_code       (error_code),
		.total_distance   (total_distance),
		.mismatches       (mismatches),
		.pending_verdicts (pending_verdicts)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= pop_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input logic [1:0] m, input logic [PORT_W-1:0] r, c,
			input logic [DIST_W-1:0] d, dr, input logic dm, input logic [PORT_W-1:0] rp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		mode <= m;
		row_port <= r;
		col_port <= c;
		leg_distance <= d;
		draft_limit <= dr;
		has_demand <= dm;
		route_port <= rp;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		if (m != MODE_UNUSED)
			words_sent++;
	endtask

	function automatic logic [DIST_W-1:0] pick_leg();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic logic [DIST_W-1:0] pick_draft(input int load);
		case ($urandom_range(0, 4))
			0: return load;
			1: return '1;
			default: return $urandom_range(load, 65535);
		endcase
	endfunction

	task automatic load_leg(input logic [PORT_W-1:0] r, c, input logic [DIST_W-1:0] d);
		send_word(MODE_DIST, r, c, d, $urandom_range(0, 65535), $urandom_range(0, 1),
			$urandom_range(0, 63));
		leg_loaded[{r, c}] = 1'b1;
	endtask

	task automatic load_port(input logic [PORT_W-1:0] p, input logic [DIST_W-1:0] dr,
			input logic dm);
		send_word(MODE_PORT, p, $urandom_range(0, 63), $urandom_range(0, 65535), dr, dm,
			$urandom_range(0, 63));
		port_loaded[p] = 1'b1;
	endtask

	// loads and unused-mode words dropped between route ports
	task automatic stray_word();
		case ($urandom_range(0, 2))
			0: load_leg($urandom_range(0, 63), $urandom_range(0, 63), pick_leg());
			1: load_port($urandom_range(0, 63), $urandom_range(0, 65535), $urandom_range(0, 1));
			default: send_word(MODE_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1),
				$urandom_range(0, 63));
		endcase
	endtask

	task automatic visit(input logic [PORT_W-1:0] p);
		if ($urandom_range(0, 99) < stray_pct)
			stray_word();
		if (!leg_loaded[{gen_prev, p}])
			load_leg(gen_prev, p, pick_leg());
		if (p != 0 && !port_loaded[p])
			load_port(p, $urandom_range(0, 65535), $urandom_range(0, 1));
		send_word(MODE_ROUTE, $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1), p);
		gen_prev = p;
		gen_pos++;
		if (gen_pos >= gen_ports) begin
			gen_pos = 0;
			gen_prev = '0;
		end
	endtask

	function automatic logic [PORT_W-1:0] noisy_port();
		if ($urandom_range(0, 99) < 60)
			return $urandom_range(0, gen_ports - 1);
		return $urandom_range(0, MAX_PORTS - 1);
	endfunction

	// a feasible tour of every port, then at most one rule broken on purpose
	task automatic run_route(input route_flaw_t flaw);
		int                order [$];
		int                n;
		int                k;
		int                j;
		int                tmp;
		logic [PORT_W-1:0] home;
		n = gen_ports;
		home = '0;
		for (int p = 1; p < n; p++)
			order.push_back(p);
		for (int i = n - 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < n - 1; i++)
			load_port(order[i], pick_draft(n - 1 - i), 1'b1);
		k = $urandom_range(0, n - 2);
		if (flaw == FLAW_INDEX && n == MAX_PORTS)
			flaw = FLAW_ORIGIN;
		if (flaw == FLAW_REPEAT && n < 3)
			flaw = FLAW_DEMAND;
		case (flaw)
			FLAW_ORIGIN: order[k] = 0;
			FLAW_INDEX:  order[k] = $urandom_range(n, MAX_PORTS - 1);
			FLAW_DRAFT:  load_port(order[k], $urandom_range(0, n - 2 - k), 1'b1);
			FLAW_DEMAND: load_port(order[k], '1, 1'b0);
			FLAW_REPEAT: begin
				k = $urandom_range(1, n - 2);
				order[k] = order[$urandom_range(0, k - 1)];
			end
			FLAW_RETURN: home = $urandom_range(1, MAX_PORTS - 1);
			default: ;
		endcase
		foreach (order[i])
			visit(order[i]);
		visit(home);
	endtask

	task automatic noise_route();
		while (gen_pos != 0 || gen_ports == 0)
			visit(noisy_port());
		repeat (gen_ports)
			visit(noisy_port());
	endtask

	// only once every verdict is out and the pipe has settled
	task automatic set_port_count(input logic [CNT_W-1:0] v);
		push <= 1'b0;
		while (pending_verdicts != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		gen_ports = (v < MIN_PORTS) ? MIN_PORTS : (v > MAX_PORTS) ? MAX_PORTS : v;
		gen_pos = 0;
		gen_prev = '0;
	endtask

	function automatic logic [CNT_W-1:0] pick_port_count(input int epoch);
		int r;
		case (epoch)
			0: return 7'd127;
			1: return 7'd0;
			2: return 7'd64;
			3: return 7'd1;
			default: begin
				r = $urandom_range(0, 99);
				if (r < 5)
					return 7'd64;
				if (r < 10)
					return $urandom_range(65, 127);
				if (r < 15)
					return $urandom_range(0, 2);
				return $urandom_range(3, 12);
			end
		endcase
	endfunction

	initial begin
		int epoch;
		int r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		push = 1'b0;
		mode = MODE_DIST;
		row_port = '0;
		col_port = '0;
		leg_distance = '0;
		draft_limit = '0;
		has_demand = 1'b0;
		route_port = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// part of a route at the reset port count, cut short by the register write
		visit(5);
		visit(9);
		load_leg(63, 63, '1);
		load_port(63, '1, 1'b1);
		send_word(MODE_UNUSED, '1, '1, '1, '1, 1'b1, '1);
		set_port_count(3);
		run_route(FLAW_NONE);
		run_route(FLAW_ORIGIN);
		run_route(FLAW_INDEX);
		run_route(FLAW_DRAFT);
		run_route(FLAW_DEMAND);
		run_route(FLAW_REPEAT);
		run_route(FLAW_RETURN);
		set_port_count(2);
		run_route(FLAW_NONE);
		run_route(FLAW_DRAFT);

		stray_pct = 8;
		epoch = 0;
		while (words_sent < ITEM_TARGET) begin
			if (words_sent >= 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 0;
				pop_idle_pct = 0;
			end else if (words_sent >= ITEM_TARGET / 3) begin
				send_idle_pct = 48;
				pop_idle_pct = 38;
			end
			set_port_count(pick_port_count(epoch));
			repeat ((gen_ports >= 32) ? 1 : $urandom_range(2, 6)) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					run_route(FLAW_NONE);
				else if (r < 85)
					run_route(route_flaw_t'($urandom_range(FLAW_ORIGIN, FLAW_RETURN)));
				else
					noise_route();
			end
			// sometimes leave a route half done for the next write to clear
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, gen_ports - 1))
					visit(noisy_port());
			epoch++;
		end

		push <= 1'b0;
		while (pending_verdicts != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_verdicts == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
